// ===== rtl/fmul25519_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the radix-2^51 multiplier modulo 2^255-19.
// Used by every module in this folder; depends on nothing.
package fmul25519_pkg;

    localparam int NLIMB     = 5;
    localparam int LIMB_BITS = 51;
    localparam int IN_BITS   = 52;
    localparam int HALF_BITS = 26;
    localparam int PP_BITS   = 52;
    localparam int PROD_BITS = 104;
    localparam int LO_BITS   = 107;
    localparam int HI_BITS   = 106;
    localparam int COL_BITS  = 112;
    localparam int CRY_BITS  = COL_BITS - LIMB_BITS;

    typedef struct packed {
        logic [IN_BITS-1:0] a_limb0;
        logic [IN_BITS-1:0] a_limb1;
        logic [IN_BITS-1:0] a_limb2;
        logic [IN_BITS-1:0] a_limb3;
        logic [IN_BITS-1:0] a_limb4;
        logic [IN_BITS-1:0] b_limb0;
        logic [IN_BITS-1:0] b_limb1;
        logic [IN_BITS-1:0] b_limb2;
        logic [IN_BITS-1:0] b_limb3;
        logic [IN_BITS-1:0] b_limb4;
    } t_in;

    typedef struct packed {
        logic [LIMB_BITS-1:0] prod_limb0;
        logic [LIMB_BITS-1:0] prod_limb1;
        logic [IN_BITS-1:0]   prod_limb2;
        logic [LIMB_BITS-1:0] prod_limb3;
        logic [LIMB_BITS-1:0] prod_limb4;
    } t_out;

    typedef logic [NLIMB-1:0][NLIMB-1:0][PROD_BITS-1:0] t_prod_arr;
    typedef logic [NLIMB-1:0][COL_BITS-1:0]             t_col_arr;

endpackage

// ===== rtl/fmul25519_mul_array.sv =====
`timescale 1ns / 1ps
// Two-stage array of the 25 limb products, each built from four 26x26 parts.
// Depends on fmul25519_pkg.
module fmul25519_mul_array (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  fmul25519_pkg::t_in       i_data,
    output logic                     o_valid,
    output fmul25519_pkg::t_prod_arr o_prod
);

    localparam int H = fmul25519_pkg::HALF_BITS;
    localparam int P = fmul25519_pkg::PP_BITS;
    localparam int W = fmul25519_pkg::PROD_BITS;
    localparam int N = fmul25519_pkg::NLIMB;

    logic [N-1:0][fmul25519_pkg::IN_BITS-1:0] a;
    logic [N-1:0][fmul25519_pkg::IN_BITS-1:0] b;

    // Partial products per limb pair: 0 = lo*lo, 1 = lo*hi, 2 = hi*lo, 3 = hi*hi.
    logic [N-1:0][N-1:0][3:0][P-1:0] n_pp, r_pp;
    logic                            r_v1;
    fmul25519_pkg::t_prod_arr        n_prod, r_prod;
    logic                            r_v2;

    assign a = {i_data.a_limb4, i_data.a_limb3, i_data.a_limb2, i_data.a_limb1, i_data.a_limb0};
    assign b = {i_data.b_limb4, i_data.b_limb3, i_data.b_limb2, i_data.b_limb1, i_data.b_limb0};

    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                n_pp[i][j][0] = P'(a[i][H-1:0])   * P'(b[j][H-1:0]);
                n_pp[i][j][1] = P'(a[i][H-1:0])   * P'(b[j][2*H-1:H]);
                n_pp[i][j][2] = P'(a[i][2*H-1:H]) * P'(b[j][H-1:0]);
                n_pp[i][j][3] = P'(a[i][2*H-1:H]) * P'(b[j][2*H-1:H]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                n_prod[i][j] = {{(W-P){1'b0}}, r_pp[i][j][0]}
                             + ({{(W-P){1'b0}}, r_pp[i][j][1]} << H)
                             + ({{(W-P){1'b0}}, r_pp[i][j][2]} << H)
                             + {r_pp[i][j][3], {(W-P){1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp   <= n_pp;
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/fmul25519_col_fold.sv =====
`timescale 1ns / 1ps
// Column sums of the limb products and the fold of high columns by 19.
// Depends on fmul25519_pkg.
module fmul25519_col_fold (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  fmul25519_pkg::t_prod_arr i_prod,
    output logic                     o_valid,
    output fmul25519_pkg::t_col_arr  o_col
);

    localparam int N  = fmul25519_pkg::NLIMB;
    localparam int W  = fmul25519_pkg::PROD_BITS;
    localparam int LW = fmul25519_pkg::LO_BITS;
    localparam int HW = fmul25519_pkg::HI_BITS;
    localparam int CW = fmul25519_pkg::COL_BITS;

    logic [N-1:0][LW-1:0]   n_lo, r_lo;
    logic [N-2:0][HW-1:0]   n_hi, r_hi;
    logic                   r_v1;
    fmul25519_pkg::t_col_arr n_col, r_col;
    logic                   r_v2;

    // Products at weight 2^255 and above land in the high sums.
    always_comb begin
        n_lo = '0;
        n_hi = '0;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                if (i + j < N) begin
                    n_lo[i+j] = n_lo[i+j] + {{(LW-W){1'b0}}, i_prod[i][j]};
                end else begin
                    n_hi[i+j-N] = n_hi[i+j-N] + {{(HW-W){1'b0}}, i_prod[i][j]};
                end
            end
        end
    end

    // Fold: col = lo + 19 * hi, with 19 * hi as shifted adds.
    always_comb begin
        for (int k = 0; k < N - 1; k++) begin
            n_col[k] = {{(CW-LW){1'b0}}, r_lo[k]}
                     + ({{(CW-HW){1'b0}}, r_hi[k]} << 4)
                     + ({{(CW-HW){1'b0}}, r_hi[k]} << 1)
                     + {{(CW-HW){1'b0}}, r_hi[k]};
        end
        n_col[N-1] = {{(CW-LW){1'b0}}, r_lo[N-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_col <= n_col;
        end
    end

    assign o_valid = r_v2;
    assign o_col   = r_col;

endmodule

// ===== rtl/fmul25519_carry.sv =====
`timescale 1ns / 1ps
// Carry chain at 51 bits, one column per stage, then the wrap by 19 and the
// short second carry. Depends on fmul25519_pkg.
module fmul25519_carry (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  fmul25519_pkg::t_col_arr i_col,
    output logic                    o_valid,
    output fmul25519_pkg::t_out     o_data
);

    localparam int N  = fmul25519_pkg::NLIMB;
    localparam int L  = fmul25519_pkg::LIMB_BITS;
    localparam int CW = fmul25519_pkg::COL_BITS;
    localparam int CB = fmul25519_pkg::CRY_BITS;
    localparam int WB = L + 16;

    logic [N-2:0][N-1:0][CW-1:0] r_col;
    logic [N-1:0][N-1:0][L-1:0]  r_lim;
    logic [N-1:0]                r_v;
    logic [CB-1:0]               r_top;

    logic [WB-1:0]               n_w, r_w;
    logic [N-1:1][L-1:0]         r_wlim;
    logic                        r_wv;

    logic [L:0]                  t1;
    fmul25519_pkg::t_out         n_out, r_out;
    logic                        r_ov;

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [N-1:0][CW-1:0] col_in;
        logic [N-1:0][L-1:0]  lim_in;
        logic                 v_in;
        logic [N-1:0][L-1:0]  n_lim;

        if (s == 0) begin : g_first
            assign col_in = i_col;
            assign lim_in = '0;
            assign v_in   = i_valid;
        end else begin : g_next
            assign col_in = r_col[s-1];
            assign lim_in = r_lim[s-1];
            assign v_in   = r_v[s-1];
        end

        always_comb begin
            n_lim    = lim_in;
            n_lim[s] = col_in[s][L-1:0];
        end

        if (s < N - 1) begin : g_mid
            logic [N-1:0][CW-1:0] n_col;
            always_comb begin
                n_col      = col_in;
                n_col[s+1] = col_in[s+1] + {{L{1'b0}}, col_in[s][CW-1:L]};
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_col[s] <= n_col;
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_top <= col_in[s][CW-1:L];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lim[s] <= n_lim;
            end
        end
    end

    // Top carry times 19 goes back into limb 0.
    assign n_w = {{(WB-L){1'b0}}, r_lim[N-1][0]}
               + ({{(WB-CB){1'b0}}, r_top} << 4)
               + ({{(WB-CB){1'b0}}, r_top} << 1)
               + {{(WB-CB){1'b0}}, r_top};

    always_comb begin
        t1               = {1'b0, r_wlim[1]} + {{(L+1-(WB-L)){1'b0}}, r_w[WB-1:L]};
        n_out.prod_limb0 = r_w[L-1:0];
        n_out.prod_limb1 = t1[L-1:0];
        n_out.prod_limb2 = {1'b0, r_wlim[2]} + {{L{1'b0}}, t1[L]};
        n_out.prod_limb3 = r_wlim[3];
        n_out.prod_limb4 = r_wlim[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_wv <= r_v[N-1];
            r_ov <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w    <= n_w;
            r_wlim <= r_lim[N-1][N-1:1];
            r_out  <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ===== rtl/field_mul_p25519_radix51_top.sv =====
`timescale 1ns / 1ps
// Top level of the pipelined radix-2^51 multiplier modulo 2^255-19.
// Depends on fmul25519_pkg, fmul25519_mul_array, fmul25519_col_fold, fmul25519_carry.
//
//   channel   direction   valid        stall        payload
//   input     in          i_in_valid   o_in_stall   i_in_data  (fmul25519_pkg::t_in)
//   output    out         o_out_valid  i_out_stall  o_out_data (fmul25519_pkg::t_out)
//
// One transfer is accepted every cycle unless a result waits under stall. The
// stages are two for the limb product array, two for column sums and the fold
// by 19, five for the carry chain (one column per stage), one for the wrap of
// the top carry and one for the second carry.
// Reset is synchronous and active low; it clears only the valid bits.
// The whole pipeline advances together and holds while a result waits under stall,
// so nothing is lost or repeated; while the output register is empty, a stall has
// no effect and the pipeline keeps moving.
module field_mul_p25519_radix51_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fmul25519_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fmul25519_pkg::t_out o_out_data
);

    // Pipeline enable: everything moves unless the final result is held.
    logic                     en;
    logic                     mul_valid;
    fmul25519_pkg::t_prod_arr mul_prod;
    logic                     col_valid;
    fmul25519_pkg::t_col_arr  col_sum;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Stages 1 and 2: 25 limb products from 26x26 partial products.
    fmul25519_mul_array u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (mul_valid),
        .o_prod  (mul_prod)
    );

    // Stages 3 and 4: direct and high column sums, then high sums times 19.
    fmul25519_col_fold u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_valid),
        .i_prod  (mul_prod),
        .o_valid (col_valid),
        .o_col   (col_sum)
    );

    // Stages 5 to 11: carry chain, wrap and second carry; the last register is
    // the output register.
    fmul25519_carry u_carry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (col_valid),
        .i_col   (col_sum),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // The input side is only held back while a result is waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // After the second carry, limb 2 never exceeds 2^51.
    a_limb2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.prod_limb2 <= 52'h8000000000000))
        else $error("product limb 2 above 2^51");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/field_mul_p25519_radix51_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for field_mul_p25519_radix51_top, the radix-2^51 multiplier modulo 2^255-19.
// Depends on fmul25519_pkg and the RTL only. A scoreboard class predicts each product
// exactly and checks the results in order, while plain tasks drive bursty, stalled traffic.
module field_mul_p25519_radix51_top_tb;

    localparam int NLIMB     = fmul25519_pkg::NLIMB;
    localparam int LIMB_BITS = fmul25519_pkg::LIMB_BITS;
    localparam int IN_BITS   = fmul25519_pkg::IN_BITS;
    localparam int COL_BITS  = fmul25519_pkg::COL_BITS;

    typedef fmul25519_pkg::t_in  t_in;
    typedef fmul25519_pkg::t_out t_out;
    typedef logic [COL_BITS-1:0] t_wide;

    // The fold factor comes from 2^255 = 19 modulo p.
    localparam t_wide       FOLD_FACTOR = 19;
    localparam logic [51:0] LIMB52_MAX  = {IN_BITS{1'b1}};
    localparam logic [51:0] LIMB51_MAX  = {1'b0, {LIMB_BITS{1'b1}}};
    localparam logic [51:0] LIMB51_BIT  = 52'd1 << LIMB_BITS;
    localparam int          RANDOM_ITEMS = 850;
    // The drain allows ample margin for a stray extra result to appear.
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 300000;

    // Five limbs of one operand; element 0 is the least significant limb.
    typedef logic [NLIMB-1:0][IN_BITS-1:0] t_elem;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    // The scoreboard holds one expected product per accepted operand pair, in order.
    class mul_scoreboard;
        t_out pending_products[$];
        int   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Exact product: schoolbook columns with the high terms folded by 19, one carry
        // chain at 51 bits, the top carry wrapped into limb 0, and a short second carry.
        function t_out field_product(t_in d);
            logic [COL_BITS-1:0] av [NLIMB];
            logic [COL_BITS-1:0] bv [NLIMB];
            logic [COL_BITS-1:0] col [NLIMB];
            logic [COL_BITS-1:0] lim [NLIMB];
            logic [COL_BITS-1:0] carry;
            logic [COL_BITS-1:0] mask;
            t_out                r;
            mask  = (t_wide'(1) << LIMB_BITS) - t_wide'(1);
            av[0] = t_wide'(d.a_limb0); av[1] = t_wide'(d.a_limb1); av[2] = t_wide'(d.a_limb2);
            av[3] = t_wide'(d.a_limb3); av[4] = t_wide'(d.a_limb4);
            bv[0] = t_wide'(d.b_limb0); bv[1] = t_wide'(d.b_limb1); bv[2] = t_wide'(d.b_limb2);
            bv[3] = t_wide'(d.b_limb3); bv[4] = t_wide'(d.b_limb4);
            for (int k = 0; k < NLIMB; k++) col[k] = '0;
            for (int i = 0; i < NLIMB; i++) begin
                for (int j = 0; j < NLIMB; j++) begin
                    if (i + j < NLIMB) begin
                        col[i + j] = col[i + j] + av[i] * bv[j];
                    end else begin
                        col[i + j - NLIMB] = col[i + j - NLIMB] + (av[i] * FOLD_FACTOR) * bv[j];
                    end
                end
            end
            carry = '0;
            for (int k = 0; k < NLIMB; k++) begin
                col[k] = col[k] + carry;
                lim[k] = col[k] & mask;
                carry  = col[k] >> LIMB_BITS;
            end
            lim[0] = lim[0] + carry * FOLD_FACTOR;
            carry  = lim[0] >> LIMB_BITS;
            lim[0] = lim[0] & mask;
            lim[1] = lim[1] + carry;
            carry  = lim[1] >> LIMB_BITS;
            lim[1] = lim[1] & mask;
            lim[2] = lim[2] + carry;
            r.prod_limb0 = lim[0][LIMB_BITS-1:0];
            r.prod_limb1 = lim[1][LIMB_BITS-1:0];
            r.prod_limb2 = lim[2][IN_BITS-1:0];
            r.prod_limb3 = lim[3][LIMB_BITS-1:0];
            r.prod_limb4 = lim[4][LIMB_BITS-1:0];
            return r;
        endfunction

        function void note_operands(t_in d);
            pending_products.push_back(field_product(d));
        endfunction

        function int pending();
            return pending_products.size();
        endfunction

        task report_mismatch(string line);
            mismatch_count++;
            $display("MISMATCH at %0t: %s", $time, line);
        endtask

        task check_limb(string name, logic [51:0] got, logic [51:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got 0x%013h expected 0x%013h", name, got, want));
            end
        endtask

        task check_product(t_out got);
            t_out want;
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("product with none expected: 0x%h", got));
            end else begin
                want = pending_products.pop_front();
                check_limb("prod_limb0", 52'(got.prod_limb0), 52'(want.prod_limb0));
                check_limb("prod_limb1", 52'(got.prod_limb1), 52'(want.prod_limb1));
                check_limb("prod_limb2", got.prod_limb2, want.prod_limb2);
                check_limb("prod_limb3", 52'(got.prod_limb3), 52'(want.prod_limb3));
                check_limb("prod_limb4", 52'(got.prod_limb4), 52'(want.prod_limb4));
            end
        endtask
    endclass

    // Every input of the block starts at a known value; reset is held from time zero.
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    mul_scoreboard sb;
    t_in           directed_q[$];
    int            cycle_count = 0;
    t_stall_mode   stall_mode  = STALL_NONE;
    int            stall_left  = 0;

    field_mul_p25519_radix51_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The watchdog ends a run that hangs. Its limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** field_mul_p25519_radix51_top: FAILED **");
            $finish;
        end
    end

    // The receiver stalls on its own pattern. A mode is held for a random stretch:
    // no stall at all, light or heavy random stall, or long runs of stall and release.
    // All changes happen at the rising edge, so they are settled by the falling edge.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if ($urandom_range(0, 7) == 0) i_out_stall <= !i_out_stall;
            end
        endcase
    end

    // Both channels are sampled at the falling edge. Everything the testbench drives
    // changes only at the rising edge, and the stall outputs follow from registers and
    // from i_out_stall, so the values seen here are the ones the next rising edge uses.
    // A transfer counts when valid is high and stall is low.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_operands(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_product(o_out_data);
        end
    end

    function automatic t_in pack_operands(t_elem a, t_elem b);
        t_in d;
        d.a_limb0 = a[0]; d.a_limb1 = a[1]; d.a_limb2 = a[2];
        d.a_limb3 = a[3]; d.a_limb4 = a[4];
        d.b_limb0 = b[0]; d.b_limb1 = b[1]; d.b_limb2 = b[2];
        d.b_limb3 = b[3]; d.b_limb4 = b[4];
        return d;
    endfunction

    function automatic t_elem uniform_elem(logic [51:0] limb);
        return {NLIMB{limb}};
    endfunction

    function automatic t_elem single_limb(int idx, logic [51:0] limb);
        t_elem e;
        e      = '0;
        e[idx] = limb;
        return e;
    endfunction

    // Random limbs of several flavors: full 52-bit values, values already below the
    // radix, the corner values, small values, single bits, and values just under the max.
    function automatic logic [51:0] rand_limb(int unsigned flavor);
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case (flavor)
            0: return w[51:0];
            1: return {1'b0, w[50:0]};
            2: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return LIMB52_MAX;
                    2:       return LIMB51_MAX;
                    3:       return LIMB51_BIT;
                    default: return w[51:0];
                endcase
            end
            3: return w[51:0] >> $urandom_range(20, 51);
            4: return 52'd1 << $urandom_range(0, 51);
            default: return LIMB52_MAX - (w[51:0] >> $urandom_range(30, 51));
        endcase
    endfunction

    function automatic t_in rand_operands();
        t_elem       a;
        t_elem       b;
        int unsigned pick;
        int unsigned flavor;
        pick = $urandom_range(0, 9);
        if (pick < 4) flavor = 0;
        else if (pick < 6) flavor = 1;
        else flavor = pick - 4;
        for (int k = 0; k < NLIMB; k++) begin
            // Now and then a limb takes a flavor of its own, to mix sizes in one operand.
            a[k] = rand_limb(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : flavor);
            b[k] = rand_limb(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : flavor);
        end
        return pack_operands(a, b);
    endfunction

    // Holds one operand pair on the input channel until it transfers. The caller
    // enters right after a rising edge and leaves right after the edge of the transfer.
    task send_operands(t_in d);
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Drops valid for a number of cycles; the payload carries junk meanwhile.
    task idle_input(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            i_in_data  <= rand_operands();
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // The prime itself in limbs, and p - 1, which is -1 modulo p.
    function automatic t_elem prime_elem(logic [51:0] low_limb);
        return {LIMB51_MAX, LIMB51_MAX, LIMB51_MAX, LIMB51_MAX, low_limb};
    endfunction

    initial begin
        int remaining;
        int burst;
        sb = new();

        // Directed operands: zeros, ones, the largest limbs, the prime and p - 1, the
        // bit just above the radix, alternating bit patterns, and one large limb at a time
        // against a full operand so that each folded term is hit at its peak.
        directed_q.push_back(pack_operands('0, '0));
        directed_q.push_back(pack_operands(uniform_elem(LIMB52_MAX), uniform_elem(LIMB52_MAX)));
        directed_q.push_back(pack_operands(uniform_elem(LIMB51_MAX), uniform_elem(LIMB51_MAX)));
        directed_q.push_back(pack_operands(prime_elem(LIMB51_MAX - 18), single_limb(0, 52'd1)));
        directed_q.push_back(pack_operands(prime_elem(LIMB51_MAX - 18),
                                           prime_elem(LIMB51_MAX - 18)));
        directed_q.push_back(pack_operands(prime_elem(LIMB51_MAX - 19),
                                           prime_elem(LIMB51_MAX - 19)));
        directed_q.push_back(pack_operands(single_limb(0, 52'd1), single_limb(0, 52'd1)));
        directed_q.push_back(pack_operands(uniform_elem(LIMB51_BIT), uniform_elem(LIMB51_BIT)));
        directed_q.push_back(pack_operands(uniform_elem(LIMB52_MAX), '0));
        directed_q.push_back(pack_operands('0, uniform_elem(LIMB52_MAX)));
        directed_q.push_back(pack_operands(uniform_elem(LIMB51_MAX), single_limb(0, 52'd2)));
        directed_q.push_back(pack_operands(uniform_elem(52'haaaaaaaaaaaaa),
                                           uniform_elem(52'h5555555555555)));
        for (int k = 0; k < NLIMB; k++) begin
            directed_q.push_back(pack_operands(single_limb(k, LIMB52_MAX),
                                               uniform_elem(LIMB52_MAX)));
            directed_q.push_back(pack_operands(uniform_elem(LIMB52_MAX),
                                               single_limb(k, LIMB52_MAX)));
        end

        // Reset is held from the start and released once.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed operands go back to back.
        foreach (directed_q[n]) send_operands(directed_q[n]);
        idle_input($urandom_range(1, 6));

        // Random traffic in bursts. Most bursts are short with short gaps; some are
        // long stretches without any idle cycle, and a zero gap keeps valid high.
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            for (int n = 0; n < burst && remaining > 0; n++) begin
                send_operands(rand_operands());
                remaining--;
            end
            idle_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end
        i_in_valid <= 1'b0;

        // Wait for every expected product, then run on through the drain so that a stray
        // extra result would still be seen by the output monitor.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("** field_mul_p25519_radix51_top: PASSED **");
        end else begin
            $display("** field_mul_p25519_radix51_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fmul25519_pkg.sv
rtl/fmul25519_mul_array.sv
rtl/fmul25519_col_fold.sv
rtl/fmul25519_carry.sv
rtl/field_mul_p25519_radix51_top.sv
tb/field_mul_p25519_radix51_top_tb.sv
